>>> hw/rtl/rsfc_pkg.sv
`timescale 1ns / 1ps

package rsfc_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int SMOOTH_SHIFT  = 4;                  // accumulator runs at 16x
    localparam int ACC_BITS      = SAMPLE_BITS + SMOOTH_SHIFT;
    localparam int COUNT_BITS    = 4;
    localparam int THRESH_BITS   = 10;
    localparam int CFG_DATA_BITS = 10;
    localparam int MEDIAN_DEPTH  = 3;
    localparam int SLOT_BITS     = 2;

    localparam logic [THRESH_BITS-1:0] JUMP_THRESHOLD_RESET = THRESH_BITS'(80);
    localparam logic [COUNT_BITS-1:0]  HOLD_WINDOW_RESET    = COUNT_BITS'(7);

    typedef enum logic {
        CMD_FILTER = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_command;

    typedef enum logic {
        CFG_JUMP_THRESHOLD = 1'b0,
        CFG_HOLD_WINDOW    = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_command               command;
        logic [SAMPLE_BITS-1:0] distance_in;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] median_out;
        logic [SAMPLE_BITS-1:0] skip_out;
        logic [SAMPLE_BITS-1:0] smooth_out;
    } t_out_item;

endpackage

>>> hw/rtl/rsfc_filter_stage.sv
`timescale 1ns / 1ps

module rsfc_filter_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  rsfc_pkg::t_in_item              i_item,
    input  logic [rsfc_pkg::THRESH_BITS-1:0] i_jump_threshold,
    input  logic [rsfc_pkg::COUNT_BITS-1:0]  i_hold_window,
    output rsfc_pkg::t_out_item             o_result
);
    import rsfc_pkg::*;

    logic [SAMPLE_BITS-1:0] r_buf [MEDIAN_DEPTH];
    logic [SLOT_BITS-1:0]   r_slot;
    logic [SAMPLE_BITS-1:0] r_held;
    logic [COUNT_BITS-1:0]  r_count;
    logic [ACC_BITS-1:0]    r_acc;

    logic [SAMPLE_BITS-1:0] n_buf [MEDIAN_DEPTH];
    logic [SLOT_BITS-1:0]   n_slot;
    logic [SAMPLE_BITS-1:0] n_held;
    logic [COUNT_BITS-1:0]  n_count;
    logic [ACC_BITS-1:0]    n_acc;

    logic [SLOT_BITS-1:0]   slot_eff;
    logic [SAMPLE_BITS-1:0] med_lo, med_hi, med;
    logic [SAMPLE_BITS-1:0] held_eff, diff, skip_val;
    logic [COUNT_BITS:0]    count_next;
    logic                   suspect;
    logic signed [ACC_BITS:0] acc_diff, acc_adj, acc_half;
    logic                   is_clear;

    assign is_clear = (i_item.command == CMD_CLEAR);

    // median of three over the buffer with the new sample written in
    always_comb begin
        slot_eff = (r_slot < SLOT_BITS'(MEDIAN_DEPTH)) ? r_slot : '0;
        for (int i = 0; i < MEDIAN_DEPTH; i++) begin
            n_buf[i] = (slot_eff == SLOT_BITS'(i)) ? i_item.distance_in : r_buf[i];
        end
        n_slot = (slot_eff == SLOT_BITS'(MEDIAN_DEPTH - 1)) ? '0 : slot_eff + 1'b1;
        med_lo = (n_buf[0] < n_buf[1]) ? n_buf[0] : n_buf[1];
        med_hi = (n_buf[0] < n_buf[1]) ? n_buf[1] : n_buf[0];
        if (n_buf[2] <= med_lo) begin
            med = med_lo;
        end else if (n_buf[2] >= med_hi) begin
            med = med_hi;
        end else begin
            med = n_buf[2];
        end
    end

    // skip filter: empty hold latches the first nonzero median
    always_comb begin
        held_eff   = (r_held == '0 && med != '0) ? med : r_held;
        diff       = (held_eff > med) ? held_eff - med : med - held_eff;
        suspect    = (diff > i_jump_threshold) || (med == '0);
        count_next = {1'b0, r_count} + 1'b1;
        skip_val   = med;
        n_count    = '0;
        if (suspect && count_next <= {1'b0, i_hold_window}) begin
            n_count  = count_next[COUNT_BITS-1:0];
            skip_val = held_eff;
        end
        n_held = skip_val;
    end

    // exponential average, half step truncated toward zero
    always_comb begin
        acc_diff = $signed({1'b0, skip_val, SMOOTH_SHIFT'(0)}) - $signed({1'b0, r_acc});
        acc_adj  = acc_diff + $signed({{ACC_BITS{1'b0}}, acc_diff[ACC_BITS]});
        acc_half = acc_adj >>> 1;
        n_acc    = (skip_val == '0) ? '0 : r_acc + acc_half[ACC_BITS-1:0];
    end

    always_comb begin
        if (is_clear) begin
            o_result = '0;
        end else begin
            o_result.median_out = med;
            o_result.skip_out   = skip_val;
            o_result.smooth_out = n_acc[ACC_BITS-1 -: SAMPLE_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && is_clear)) begin
            for (int i = 0; i < MEDIAN_DEPTH; i++) begin
                r_buf[i] <= '0;
            end
            r_slot  <= '0;
            r_held  <= '0;
            r_count <= '0;
            r_acc   <= '0;
        end else if (i_en) begin
            for (int i = 0; i < MEDIAN_DEPTH; i++) begin
                r_buf[i] <= n_buf[i];
            end
            r_slot  <= n_slot;
            r_held  <= n_held;
            r_count <= n_count;
            r_acc   <= n_acc;
        end
    end

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != SLOT_BITS'(MEDIAN_DEPTH))
        else $error("median slot out of range");

    a_held_tracks_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> r_held == $past(o_result.skip_out))
        else $error("held value differs from last skip output");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && is_clear |=> r_acc == '0 && r_count == '0 && r_slot == '0)
        else $error("clear left filter state");

    a_zero_skip_zero_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && !is_clear && skip_val == '0 |=> r_acc == '0)
        else $error("accumulator not zeroed on zero input");
`endif

endmodule

>>> hw/rtl/range_sample_filter_chain.sv
`timescale 1ns / 1ps
// Each sample passes through the input register, then the result register, and its result
// is offered from the result register until it is taken.
// Throughput: one sample per cycle; a new sample is taken while a result waits in the
// output register, and the pipe stalls only when both registers are full and the result
// is not taken.
// Reset (synchronous, active low) zeroes all filter state and sets jump_threshold to 80
// and hold_window to 7; no clearing pass is needed.

module range_sample_filter_chain (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rsfc_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rsfc_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  rsfc_pkg::t_cfg_index              i_cfg_index,
    input  logic [rsfc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import rsfc_pkg::*;

    logic                   r_in_valid;
    t_in_item               r_in_item;
    logic                   r_out_valid;
    t_out_item              r_out_item;
    logic [THRESH_BITS-1:0] r_jump_threshold;
    logic [COUNT_BITS-1:0]  r_hold_window;

    logic      advance;
    logic      in_xfer;
    t_out_item result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    rsfc_filter_stage u_filter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (advance),
        .i_item           (r_in_item),
        .i_jump_threshold (r_jump_threshold),
        .i_hold_window    (r_hold_window),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_threshold <= JUMP_THRESHOLD_RESET;
            r_hold_window    <= HOLD_WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_JUMP_THRESHOLD: r_jump_threshold <= i_cfg_data[THRESH_BITS-1:0];
                CFG_HOLD_WINDOW:    r_hold_window    <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipe");

    a_clear_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_item.command == CMD_CLEAR |=> o_out_item == '0)
        else $error("clear transfer produced nonzero result");
`endif

endmodule
